// ===== src/bla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bla_pkg;

    localparam int COORD_W_DEF   = 32;
    localparam int SCL_W         = 29;    // scaled vector components stay below 2^29
    localparam int NUV_W         = 60;    // squared norm of a scaled vector
    localparam int DOT_W         = 61;    // signed dot product of scaled vectors
    localparam int HALF_W        = 30;    // partial product split point
    localparam int SQ_W          = 60;    // root width of |u|^2 |v|^2 - dot^2
    localparam int CORDIC_STEPS  = 30;
    localparam int CXW           = 64;    // cordic x/y width
    localparam int ZW            = 34;    // cordic angle accumulator, Q4.30 signed
    localparam int LEN_W         = 32;
    localparam int ANG_W         = 24;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [ZW-1:0]    HALF_PI_Q30    = 34'd1686629713;
    localparam logic [31:0]      RAD_TO_DEG_Q26 = 32'd3845054675;
    localparam logic [ANG_W-1:0] ANGLE_MAX      = 24'd11796480;

    localparam logic ACT_BOND  = 1'b0;
    localparam logic ACT_ANGLE = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [NUV_W-1:0]        nu;
        logic [NUV_W-1:0]        nv;
        logic signed [DOT_W-1:0] dot;
    } bla_angle_t;

    typedef struct packed {
        logic action;
        logic degen;
        logic dneg;
        logic dpos;
        logic szero;
    } bla_tag_t;

    function automatic logic [ZW-1:0] atan_q30(input int k);
        logic [ZW-1:0] r;
        case (k)
            0: r = 34'd843314856;
            1: r = 34'd497837829;
            2: r = 34'd263043836;
            3: r = 34'd133525158;
            4: r = 34'd67021686;
            5: r = 34'd33543515;
            6: r = 34'd16775850;
            7: r = 34'd8388437;
            8: r = 34'd4194282;
            9: r = 34'd2097149;
            10: r = 34'd1048575;
            11: r = 34'd524287;
            12: r = 34'd262143;
            13: r = 34'd131071;
            14: r = 34'd65535;
            15: r = 34'd32767;
            16: r = 34'd16383;
            17: r = 34'd8191;
            18: r = 34'd4095;
            19: r = 34'd2047;
            20: r = 34'd1023;
            21: r = 34'd511;
            22: r = 34'd255;
            23: r = 34'd127;
            24: r = 34'd63;
            25: r = 34'd31;
            26: r = 34'd15;
            27: r = 34'd7;
            28: r = 34'd3;
            29: r = 34'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/bla_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bla_front import bla_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_action,
    input  wire logic [9*COORD_WIDTH-1:0]   in_coords,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output bla_angle_t                      out_work,
    output logic [2*COORD_WIDTH+1:0]        out_lsum
);
    localparam int CW = COORD_WIDTH;
    localparam int MX = (CW > SCL_W) ? CW : SCL_W;
    localparam int LW = 2 * CW + 2;

    logic              en;
    logic [4:0]        v_reg;
    logic [4:0]        act_reg;

    logic signed [CW:0] du_next [3];
    logic signed [CW:0] dv_next [3];
    logic signed [CW:0] du_reg [3];
    logic signed [CW:0] dv_reg [3];

    logic [CW-1:0] mu_reg [3];
    logic [CW-1:0] mv_reg [3];
    logic          su_reg [3];
    logic          sv_reg [3];

    logic [SCL_W-1:0]  cu_next [3];
    logic [SCL_W-1:0]  cv_next [3];
    logic [SCL_W-1:0]  cu_reg [3];
    logic [SCL_W-1:0]  cv_reg [3];
    logic              neg3_reg [3];
    logic [2*CW-1:0]   dd_reg [3];

    logic [2*SCL_W-1:0] uu_reg [3];
    logic [2*SCL_W-1:0] vv_reg [3];
    logic [2*SCL_W-1:0] uv_reg [3];
    logic               neg4_reg [3];
    logic [LW-1:0]      lsum4_reg;

    bla_angle_t     work_next;
    bla_angle_t     work_reg;
    logic [LW-1:0]  lsum_reg;

    assign en        = !(v_reg[4] && !out_ready);
    assign in_ready  = en;
    assign out_valid = v_reg[4];
    assign out_work  = work_reg;
    assign out_lsum  = lsum_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            du_next[k] = {in_coords[k*CW+CW-1], in_coords[k*CW +: CW]}
                       - {in_coords[(k+3)*CW+CW-1], in_coords[(k+3)*CW +: CW]};
            dv_next[k] = {in_coords[(k+6)*CW+CW-1], in_coords[(k+6)*CW +: CW]}
                       - {in_coords[(k+3)*CW+CW-1], in_coords[(k+3)*CW +: CW]};
        end
    end

    // shift each vector right until its largest component is below 2^29
    always_comb begin
        logic [CW-1:0] or_u;
        logic [CW-1:0] or_v;
        int            bl_u;
        int            bl_v;
        int            sh_u;
        int            sh_v;
        logic [MX-1:0] xu;
        logic [MX-1:0] xv;
        or_u = mu_reg[0] | mu_reg[1] | mu_reg[2];
        or_v = mv_reg[0] | mv_reg[1] | mv_reg[2];
        bl_u = 0;
        bl_v = 0;
        for (int b = 0; b < CW; b++) begin
            if (or_u[b]) bl_u = b + 1;
            if (or_v[b]) bl_v = b + 1;
        end
        sh_u = (bl_u > SCL_W) ? bl_u - SCL_W : 0;
        sh_v = (bl_v > SCL_W) ? bl_v - SCL_W : 0;
        for (int k = 0; k < 3; k++) begin
            xu = MX'(mu_reg[k]) >> sh_u;
            xv = MX'(mv_reg[k]) >> sh_v;
            cu_next[k] = xu[SCL_W-1:0];
            cv_next[k] = xv[SCL_W-1:0];
        end
    end

    always_comb begin
        logic signed [DOT_W-1:0] t;
        logic signed [DOT_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            t = DOT_W'(uv_reg[k]);
            if (neg4_reg[k]) t = -t;
            acc = acc + t;
        end
        work_next.action = act_reg[3];
        work_next.nu     = NUV_W'(uu_reg[0]) + NUV_W'(uu_reg[1]) + NUV_W'(uu_reg[2]);
        work_next.nv     = NUV_W'(vv_reg[0]) + NUV_W'(vv_reg[1]) + NUV_W'(vv_reg[2]);
        work_next.dot    = acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg     <= {v_reg[3:0], in_valid};
            act_reg   <= {act_reg[3:0], in_action};
            for (int k = 0; k < 3; k++) begin
                du_reg[k]   <= du_next[k];
                dv_reg[k]   <= dv_next[k];
                mu_reg[k]   <= du_reg[k][CW] ? CW'(-du_reg[k]) : CW'(du_reg[k]);
                mv_reg[k]   <= dv_reg[k][CW] ? CW'(-dv_reg[k]) : CW'(dv_reg[k]);
                su_reg[k]   <= du_reg[k][CW];
                sv_reg[k]   <= dv_reg[k][CW];
                cu_reg[k]   <= cu_next[k];
                cv_reg[k]   <= cv_next[k];
                neg3_reg[k] <= su_reg[k] ^ sv_reg[k];
                dd_reg[k]   <= mu_reg[k] * mu_reg[k];
                uu_reg[k]   <= cu_reg[k] * cu_reg[k];
                vv_reg[k]   <= cv_reg[k] * cv_reg[k];
                uv_reg[k]   <= cu_reg[k] * cv_reg[k];
                neg4_reg[k] <= neg3_reg[k];
            end
            lsum4_reg <= LW'(dd_reg[0]) + LW'(dd_reg[1]) + LW'(dd_reg[2]);
            work_reg  <= work_next;
            lsum_reg  <= lsum4_reg;
        end
    end

endmodule
`default_nettype wire

// ===== src/bla_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bla_queue import bla_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== src/bla_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bla_back import bla_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire bla_angle_t               in_work,
    input  wire logic [2*COORD_WIDTH+1:0] in_lsum,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [LEN_W-1:0]              out_length,
    output logic [ANG_W-1:0]              out_angle,
    output logic                          out_degen
);
    localparam int CW = COORD_WIDTH;
    localparam int RW = CW + 1;
    localparam int LW = 2 * RW;
    localparam int EW = (RW > LEN_W) ? RW : LEN_W + 1;
    localparam int N  = SQ_W;
    localparam int DW = 2 * SQ_W;

    logic en;

    // partial products of |u|^2 |v|^2 and dot^2
    logic [2*HALF_W-1:0]     phh_reg, phl_reg, plh_reg, pll_reg;
    logic [2*HALF_W-1:0]     qhh_reg, qhl_reg, qll_reg;
    logic [NUV_W-1:0]        dm;
    bla_tag_t                tag1_next;
    bla_tag_t                tag1_reg, tag2_reg;
    logic signed [DOT_W-1:0] dot1_reg, dot2_reg;
    logic [LW-1:0]           ls1_reg, ls2_reg;
    logic [DW-1:0]           pp_reg, qq_reg;
    logic                    v1_reg, v2_reg;

    // square root pipeline, entry 0 is the difference stage
    logic [DW-1:0]           sd_reg [N+1];
    logic [N-1:0]            sroot_reg [N+1];
    logic [N+1:0]            srem_reg [N+1];
    logic [LW-1:0]           ld_reg [N+1];
    logic [RW-1:0]           lroot_reg [N+1];
    logic [RW+1:0]           lrem_reg [N+1];
    bla_tag_t                stag_reg [N+1];
    logic signed [DOT_W-1:0] sdot_reg [N+1];
    logic                    sv_reg [N+1];

    // cordic pipeline, entry 0 is the start vector
    logic signed [CXW-1:0]   cx_reg [CORDIC_STEPS+1];
    logic signed [CXW-1:0]   cy_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    cz_reg [CORDIC_STEPS+1];
    bla_tag_t                ctag_reg [CORDIC_STEPS+1];
    logic [RW-1:0]           clen_reg [CORDIC_STEPS+1];
    logic                    cv_reg [CORDIC_STEPS+1];
    bla_tag_t                ctag0_next;

    logic [63:0]             prod_reg;
    bla_tag_t                dtag_reg;
    logic [RW-1:0]           dlen_reg;
    logic                    dv_reg;

    logic [LEN_W-1:0]        len_reg;
    logic [ANG_W-1:0]        ang_reg;
    logic                    degen_reg;
    logic                    ov_reg;

    assign en         = out_ready || !ov_reg;
    assign in_ready   = en;
    assign out_valid  = ov_reg;
    assign out_length = len_reg;
    assign out_angle  = ang_reg;
    assign out_degen  = degen_reg;

    always_comb begin
        logic signed [DOT_W-1:0] nd;
        nd = -in_work.dot;
        dm = in_work.dot[DOT_W-1] ? nd[NUV_W-1:0] : in_work.dot[NUV_W-1:0];
        tag1_next.action = in_work.action;
        tag1_next.degen  = (in_work.nu == '0) || (in_work.nv == '0);
        tag1_next.dneg   = in_work.dot[DOT_W-1];
        tag1_next.dpos   = !in_work.dot[DOT_W-1] && (in_work.dot != '0);
        tag1_next.szero  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            phh_reg  <= in_work.nu[NUV_W-1:HALF_W] * in_work.nv[NUV_W-1:HALF_W];
            phl_reg  <= in_work.nu[NUV_W-1:HALF_W] * in_work.nv[HALF_W-1:0];
            plh_reg  <= in_work.nu[HALF_W-1:0] * in_work.nv[NUV_W-1:HALF_W];
            pll_reg  <= in_work.nu[HALF_W-1:0] * in_work.nv[HALF_W-1:0];
            qhh_reg  <= dm[NUV_W-1:HALF_W] * dm[NUV_W-1:HALF_W];
            qhl_reg  <= dm[NUV_W-1:HALF_W] * dm[HALF_W-1:0];
            qll_reg  <= dm[HALF_W-1:0] * dm[HALF_W-1:0];
            tag1_reg <= tag1_next;
            dot1_reg <= in_work.dot;
            ls1_reg  <= in_lsum;

            v2_reg   <= v1_reg;
            pp_reg   <= {phh_reg, {(2*HALF_W){1'b0}}}
                      + ((DW'(phl_reg) + DW'(plh_reg)) << HALF_W) + DW'(pll_reg);
            qq_reg   <= {qhh_reg, {(2*HALF_W){1'b0}}}
                      + (DW'(qhl_reg) << (HALF_W + 1)) + DW'(qll_reg);
            tag2_reg <= tag1_reg;
            dot2_reg <= dot1_reg;
            ls2_reg  <= ls1_reg;

            sv_reg[0]    <= v2_reg;
            sd_reg[0]    <= pp_reg - qq_reg;
            sroot_reg[0] <= '0;
            srem_reg[0]  <= '0;
            ld_reg[0]    <= ls2_reg;
            lroot_reg[0] <= '0;
            lrem_reg[0]  <= '0;
            stag_reg[0]  <= tag2_reg;
            sdot_reg[0]  <= dot2_reg;
        end
    end

    // one root bit per stage for both square roots, for the length root only in the first RW stages
    for (genvar i = 0; i < N; i++) begin : g_sqrt
        logic [N+1:0]  cand;
        logic [N+1:0]  trial;
        logic [N+1:0]  rem_next;
        logic [N-1:0]  root_next;
        logic [RW+1:0] lcand;
        logic [RW+1:0] ltrial;
        logic [RW+1:0] lrem_next;
        logic [RW-1:0] lroot_next;

        always_comb begin
            cand  = {srem_reg[i][N-1:0], sd_reg[i][DW-1 -: 2]};
            trial = {sroot_reg[i], 2'b01};
            if (cand >= trial) begin
                rem_next  = cand - trial;
                root_next = {sroot_reg[i][N-2:0], 1'b1};
            end else begin
                rem_next  = cand;
                root_next = {sroot_reg[i][N-2:0], 1'b0};
            end
            lcand  = {lrem_reg[i][RW-1:0], ld_reg[i][LW-1 -: 2]};
            ltrial = {lroot_reg[i], 2'b01};
            if (i >= RW) begin
                lrem_next  = lrem_reg[i];
                lroot_next = lroot_reg[i];
            end else if (lcand >= ltrial) begin
                lrem_next  = lcand - ltrial;
                lroot_next = {lroot_reg[i][RW-2:0], 1'b1};
            end else begin
                lrem_next  = lcand;
                lroot_next = {lroot_reg[i][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[i+1] <= 1'b0;
            end else if (en) begin
                sv_reg[i+1]    <= sv_reg[i];
                sd_reg[i+1]    <= sd_reg[i] << 2;
                srem_reg[i+1]  <= rem_next;
                sroot_reg[i+1] <= root_next;
                ld_reg[i+1]    <= ld_reg[i] << 2;
                lrem_reg[i+1]  <= lrem_next;
                lroot_reg[i+1] <= lroot_next;
                stag_reg[i+1]  <= stag_reg[i];
                sdot_reg[i+1]  <= sdot_reg[i];
            end
        end
    end

    always_comb begin
        ctag0_next       = stag_reg[N];
        ctag0_next.szero = (sroot_reg[N] == '0);
    end

    // start vector: obtuse angles are pre-rotated by a quarter turn
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0]         <= sv_reg[N];
            ctag_reg[0]       <= ctag0_next;
            clen_reg[0]       <= lroot_reg[N];
            if (stag_reg[N].dneg) begin
                cx_reg[0] <= CXW'(sroot_reg[N]);
                cy_reg[0] <= -CXW'(sdot_reg[N]);
                cz_reg[0] <= HALF_PI_Q30;
            end else begin
                cx_reg[0] <= CXW'(sdot_reg[N]);
                cy_reg[0] <= CXW'(sroot_reg[N]);
                cz_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        localparam logic [ZW-1:0] ATAN = atan_q30(k);
        logic signed [CXW-1:0] xs;
        logic signed [CXW-1:0] ys;
        assign xs = cx_reg[k] >>> k;
        assign ys = cy_reg[k] >>> k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[k+1] <= 1'b0;
            end else if (en) begin
                cv_reg[k+1]   <= cv_reg[k];
                ctag_reg[k+1] <= ctag_reg[k];
                clen_reg[k+1] <= clen_reg[k];
                // a vector already on the axis stays put
                if (cy_reg[k] == '0) begin
                    cx_reg[k+1] <= cx_reg[k];
                    cy_reg[k+1] <= cy_reg[k];
                    cz_reg[k+1] <= cz_reg[k];
                end else if (!cy_reg[k][CXW-1]) begin
                    cx_reg[k+1] <= cx_reg[k] + ys;
                    cy_reg[k+1] <= cy_reg[k] - xs;
                    cz_reg[k+1] <= cz_reg[k] + ATAN;
                end else begin
                    cx_reg[k+1] <= cx_reg[k] - ys;
                    cy_reg[k+1] <= cy_reg[k] + xs;
                    cz_reg[k+1] <= cz_reg[k] - ATAN;
                end
            end
        end
    end

    logic [31:0]      zc;
    logic [64:0]      deg_sum;
    logic [ANG_W:0]   deg_wide;
    logic [ANG_W-1:0] ang_next;
    logic             degen_next;
    logic [EW-1:0]    len_ext;
    logic [LEN_W-1:0] len_next;

    assign zc = cz_reg[CORDIC_STEPS][ZW-1] ? '0 : cz_reg[CORDIC_STEPS][31:0];

    always_comb begin
        deg_sum  = {1'b0, prod_reg} + (65'd1 << 39);
        deg_wide = deg_sum[64:40];
        len_ext  = EW'(dlen_reg);
        len_next = (len_ext[EW-1:LEN_W] != '0) ? '1 : len_ext[LEN_W-1:0];
        ang_next   = '0;
        degen_next = 1'b0;
        if (dtag_reg.action == ACT_ANGLE) begin
            if (dtag_reg.degen) begin
                degen_next = 1'b1;
            end else if (dtag_reg.szero) begin
                ang_next = dtag_reg.dpos ? '0 : ANGLE_MAX;
            end else if (deg_wide > (ANG_W+1)'(ANGLE_MAX)) begin
                ang_next = ANGLE_MAX;
            end else begin
                ang_next = deg_wide[ANG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            dv_reg    <= cv_reg[CORDIC_STEPS];
            prod_reg  <= zc * RAD_TO_DEG_Q26;
            dtag_reg  <= ctag_reg[CORDIC_STEPS];
            dlen_reg  <= clen_reg[CORDIC_STEPS];
            ov_reg    <= dv_reg;
            len_reg   <= len_next;
            ang_reg   <= ang_next;
            degen_reg <= degen_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/bond_length_and_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bond length and bond angle for three atom positions in signed Q16.16. Every word
// returns the distance from the first to the middle atom (unsigned Q16.16, saturating);
// with action 1 it also returns the angle at the middle atom in degrees as Q8.16
// (0 to 180), or flags a zero-length vector as degenerate. A new word is taken every
// clock unless m_tready back-pressure stalls it; the path has 5 front stages, the queue,
// and a back pipeline with the 60-stage square root of |u|^2 |v|^2 - dot^2 and 30 cordic steps.
module bond_length_and_angle import bla_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // first_x, first_y, first_z, middle_x, middle_y, middle_z, last_x, last_y, last_z
    input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // action
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // length, angle_degrees
    output logic [LEN_W+ANG_W-1:0]                     m_tdata,
    // degenerate
    output logic                                       m_tuser
);
    localparam int CW = COORD_WIDTH;
    localparam int LW = 2 * CW + 2;
    localparam int QW = $bits(bla_angle_t) + LW;

    logic             f_valid;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic             b_ready;
    bla_angle_t       f_work;
    logic [LW-1:0]    f_lsum;
    logic [QW-1:0]    q_out;
    bla_angle_t       b_work;
    logic [LW-1:0]    b_lsum;
    logic [LEN_W-1:0] len;
    logic [ANG_W-1:0] ang;

    bla_front #(.COORD_WIDTH(CW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_coords (s_tdata[9*CW-1:0]),
        .out_valid (f_valid),
        .out_ready (!q_full),
        .out_work  (f_work),
        .out_lsum  (f_lsum)
    );

    assign q_push = f_valid && !q_full;
    assign q_pop  = b_ready && !q_empty;

    bla_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_lsum, f_work}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign b_work = q_out[$bits(bla_angle_t)-1:0];
    assign b_lsum = q_out[QW-1:$bits(bla_angle_t)];

    bla_back #(.COORD_WIDTH(CW)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (!q_empty),
        .in_ready   (b_ready),
        .in_work    (b_work),
        .in_lsum    (b_lsum),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_length (len),
        .out_angle  (ang),
        .out_degen  (m_tuser)
    );

    assign m_tdata = {ang, len};

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[LEN_W+ANG_W-1:LEN_W] == '0)
        else $error("degenerate word with nonzero angle");

    a_angle_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[LEN_W+ANG_W-1:LEN_W] <= ANGLE_MAX)
        else $error("angle above 180 degrees");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !q_push)
        else $error("activity right after reset");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import bla_pkg::*;

    localparam int CW = COORD_W_DEF;
    localparam int DW = ((9*CW+7)/8)*8;
    localparam longint LIMIT = 400000;

    typedef struct {
        logic         action;
        logic [CW-1:0] c [9];
    } query_t;

    typedef struct {
        logic [LEN_W-1:0] length;
        logic [ANG_W-1:0] angle;
        logic             degen;
    } answer_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [LEN_W+ANG_W-1:0] m_tdata;
    logic m_tuser;

    query_t  pending_queries[$];
    answer_t expected_answers[$];
    int      mismatches = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    bit      stimulus_done = 0;
    longint  cycle_count = 0;

    bond_length_and_angle dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // floor square root of a value up to 128 bits
    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0] r, c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint signed shift_mag(longint signed v, int s);
        longint signed q;
        q = (v < 0) ? -v : v;
        q = q >>> s;
        return (v < 0) ? -q : q;
    endfunction

    // shrink so every component stays below 2^29, truncating magnitudes
    function automatic void shrink(ref longint signed w [3]);
        longint signed m;
        int s;
        m = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
            if ((w[k] < 0 ? -w[k] : w[k]) > m) m = (w[k] < 0 ? -w[k] : w[k]);
        while ((m >>> s) >= (64'sd1 <<< 29)) s++;
        for (int k = 0; k < 3; k++) w[k] = shift_mag(w[k], s);
    endfunction

    function automatic longint signed asr_floor(longint signed v, int s);
        return v >>> s;
    endfunction

    function automatic logic [ANG_W-1:0] vertex_angle(longint signed u [3],
            longint signed v [3], output logic degen);
        longint signed nu, nv, dot, x, y, z, xs, ys;
        logic [127:0] prod, dd;
        logic [63:0] s, mdot;
        logic [127:0] deg;
        nu = 0; nv = 0; dot = 0;
        shrink(u);
        shrink(v);
        for (int k = 0; k < 3; k++) begin
            nu += u[k] * u[k];
            nv += v[k] * v[k];
            dot += u[k] * v[k];
        end
        if (nu == 0 || nv == 0) begin
            degen = 1;
            return 0;
        end
        degen = 0;
        mdot = (dot < 0) ? -dot : dot;
        prod = {64'd0, nu} * {64'd0, nv};
        dd = {64'd0, mdot} * {64'd0, mdot};
        s = isqrt(prod - dd);
        if (s == 0) return (dot > 0) ? '0 : ANGLE_MAX;
        if (dot < 0) begin
            x = s; y = -dot; z = HALF_PI_Q30;
        end else begin
            x = dot; y = s; z = 0;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (y == 0) break;
            xs = asr_floor(x, k);
            ys = asr_floor(y, k);
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(atan_q30(k));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_q30(k));
            end
        end
        if (z < 0) z = 0;
        deg = ({64'd0, z} * 128'd3845054675 + (128'd1 << 39)) >> 40;
        return (deg > ANGLE_MAX) ? ANGLE_MAX : deg[ANG_W-1:0];
    endfunction

    function automatic answer_t measure(query_t q);
        answer_t a;
        longint signed p [9];
        longint signed u [3], v [3];
        logic [127:0] acc;
        logic [63:0] len, d;
        acc = 0;
        for (int k = 0; k < 9; k++) p[k] = longint'($signed(q.c[k]));
        for (int k = 0; k < 3; k++) begin
            u[k] = p[k] - p[3+k];
            v[k] = p[6+k] - p[3+k];
            d = (u[k] < 0) ? -u[k] : u[k];
            acc += {64'd0, d} * {64'd0, d};
        end
        len = isqrt(acc);
        a.length = (len > 64'hFFFF_FFFF) ? '1 : len[31:0];
        a.angle = 0;
        a.degen = 0;
        if (q.action == ACT_ANGLE) a.angle = vertex_angle(u, v, a.degen);
        return a;
    endfunction

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0000_3FFF) - 32'h0000_2000;
        endcase
    endfunction

    task automatic add_query(logic act, logic [CW-1:0] a0, logic [CW-1:0] a1,
            logic [CW-1:0] a2, logic [CW-1:0] b0, logic [CW-1:0] b1, logic [CW-1:0] b2,
            logic [CW-1:0] c0, logic [CW-1:0] c1, logic [CW-1:0] c2);
        query_t q;
        q.action = act;
        q.c[0] = a0; q.c[1] = a1; q.c[2] = a2;
        q.c[3] = b0; q.c[4] = b1; q.c[5] = b2;
        q.c[6] = c0; q.c[7] = c1; q.c[8] = c2;
        pending_queries.insert(pending_queries.size(), q);
    endtask

    localparam logic [CW-1:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] MINC = 32'h8000_0000;
    localparam logic [CW-1:0] ONE  = 32'h0001_0000;

    initial begin
        query_t q;
        int mode;
        // directed: extremes, saturation, degenerate, straight and folded angles
        add_query(ACT_BOND, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_query(ACT_ANGLE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_query(ACT_BOND, MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, 0, 0);
        add_query(ACT_ANGLE, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC);
        add_query(ACT_BOND, MINC, MINC, MINC, MAXC, MAXC, MAXC, '1, '1, '1);
        add_query(ACT_BOND, ONE, 0, 0, 0, 0, 0, 5, 6, 7);
        add_query(ACT_ANGLE, ONE, 0, 0, 0, 0, 0, 0, ONE, 0);
        add_query(ACT_ANGLE, ONE, 0, 0, 0, 0, 0, 2*ONE, 0, 0);
        add_query(ACT_ANGLE, ONE, 0, 0, 0, 0, 0, -ONE, 0, 0);
        add_query(ACT_ANGLE, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0);
        add_query(ACT_ANGLE, 0, 0, 0, ONE, 0, 0, ONE, 0, 0);
        add_query(ACT_ANGLE, ONE, 0, 0, 0, 0, 0, -ONE, 1, 0);
        add_query(ACT_ANGLE, ONE, 0, 0, 0, 0, 0, ONE, 1, 0);
        add_query(ACT_ANGLE, MAXC, 0, 0, MINC, 0, 0, MINC, 1, 0);
        add_query(ACT_ANGLE, MAXC, MAXC, 0, MINC, 0, MINC, 0, MAXC, MAXC);
        add_query(ACT_ANGLE, 1, 0, 0, 0, 0, 0, 0, 1, 0);
        add_query(ACT_ANGLE, 1, 1, 1, 0, 0, 0, MAXC, MAXC, MAXC);
        add_query(ACT_ANGLE, '1, '1, '1, 0, 0, 0, 1, 1, 1);
        add_query(ACT_ANGLE, ONE, ONE, 0, 0, 0, 0, -ONE, ONE, 0);
        for (int i = 0; i < 500; i++) begin
            q.action = $urandom_range(0, 3) != 0;
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++) q.c[k] = rand_coord(mode);
            // occasional collinear or coincident point
            if ($urandom_range(0, 15) == 0)
                for (int k = 0; k < 3; k++) q.c[6+k] = q.c[3+k];
            if ($urandom_range(0, 15) == 0)
                for (int k = 0; k < 3; k++) q.c[6+k] = 2*q.c[k] - q.c[3+k];
            pending_queries.insert(pending_queries.size(), q);
        end
        stimulus_done = 1;
    end

    // driver
    always @(posedge aclk) begin
        query_t q;
        logic [DW-1:0] packed_coords;
        if (cycle_count == 11) aresetn <= 1;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 0;
                end else if (pending_queries.size() > 0) begin
                    q = pending_queries.pop_front();
                    packed_coords = '0;
                    for (int k = 0; k < 9; k++) packed_coords[k*CW +: CW] = q.c[k];
                    s_tdata <= packed_coords;
                    s_tuser <= q.action;
                    s_tvalid <= 1;
                    expected_answers.insert(expected_answers.size(), measure(q));
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t e;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: data %h user %b", m_tdata, m_tuser);
                end else begin
                    e = expected_answers.pop_front();
                    if (m_tdata[LEN_W-1:0] !== e.length ||
                            m_tdata[LEN_W +: ANG_W] !== e.angle || m_tuser !== e.degen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: length %h/%h angle %h/%h degen %b/%b",
                                e.length, m_tdata[LEN_W-1:0], e.angle,
                                m_tdata[LEN_W +: ANG_W], e.degen, m_tuser);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while ((pending_queries.size() > 0 || expected_answers.size() > 0 || s_tvalid)
                && cycle_count < LIMIT)
            @(posedge aclk);
        if (cycle_count >= LIMIT) begin
            $display("bond_length_and_angle regression: fail");
        end else begin
            repeat (200) @(posedge aclk);
            if (mismatches == 0 && expected_answers.size() == 0) begin
                $display("bond_length_and_angle regression: pass");
            end else begin
                $display("bond_length_and_angle regression: fail");
            end
        end
        $finish;
    end

endmodule
